// ===== rtl/core/b64d_pkg.sv =====
package b64d_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned CountW = 10;
  localparam int unsigned ClassW = 7;

  localparam logic [ClassW-1:0] CLS_PAD = 7'd64;
  localparam logic [ClassW-1:0] CLS_BAD = 7'd65;

  localparam logic [CountW-1:0] CAPACITY_RST = 10'd1023;

  // held input item between the input register and the decoder
  typedef struct packed {
    logic              valid;
    logic [CharW-1:0]  ch;
    logic              last;
  } in_item_t;

  // 0..63 sextet value, CLS_PAD for '=', CLS_BAD otherwise
  function automatic logic [ClassW-1:0] char_class(input logic [CharW-1:0] ch);
    logic [ClassW-1:0] cls;
    cls = CLS_BAD;
    if (ch >= 8'h41 && ch <= 8'h5a) begin
      cls = {1'b0, ch[5:0] - 6'h01};
    end else if (ch >= 8'h61 && ch <= 8'h7a) begin
      cls = {1'b0, ch[5:0] - 6'h21 + 6'd26};
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      cls = {1'b0, ch[5:0] - 6'h30 + 6'd52};
    end else if (ch == 8'h2b) begin
      cls = 7'd62;
    end else if (ch == 8'h2f) begin
      cls = 7'd63;
    end else if (ch == 8'h3d) begin
      cls = CLS_PAD;
    end
    return cls;
  endfunction

endpackage

// ===== rtl/core/base64_stream_decoder_top.sv =====
// Strict base64 stream decoder, one source character per item.
// Input channel: in_valid/in_stall with in_char and in_last_char, which
// marks the final character of a message. Result channel: out_valid/
// out_stall with out_byte, out_byte_valid, out_done_res, out_decode_error
// and out_byte_count. Every input item gives exactly one result item.
// cfg_valid/cfg_ready writes the output capacity; cfg_ready is always high
// and writes are expected only while the decoder is idle.
// An accepted item first sits in the input register, then the decode logic
// loads the result register, which drives the ports. Throughput is one item
// per cycle while the receiver does not stall, set by the combinational
// decode and state update between those two registers.
// When the receiver stalls, the result holds, the input register fills and
// in_stall rises in the same cycle, so nothing is lost or repeated.
// Reset clears the message state and the valid flags of both pipeline
// registers and sets the capacity to 1023. The message state also returns to
// reset after each item flagged last; out_decode_error with out_done_res tells
// the caller to discard the bytes of that message.
module base64_stream_decoder_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [b64d_pkg::CharW-1:0]   in_char,
  input  logic                         in_last_char,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_byte,
  output logic                         out_byte_valid,
  output logic                         out_done_res,
  output logic                         out_decode_error,
  output logic [b64d_pkg::CountW-1:0]  out_byte_count,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [b64d_pkg::CountW-1:0]  cfg_out_capacity
);

  b64d_pkg::in_item_t           item;
  logic                         advance;
  logic [b64d_pkg::CountW-1:0]  capacity_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= b64d_pkg::CAPACITY_RST;
    end else if (cfg_valid && cfg_ready) begin
      capacity_r <= cfg_out_capacity;
    end
  end

  b64d_in_stage u_in_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char      (in_char),
    .in_last_char (in_last_char),
    .advance      (advance),
    .item         (item)
  );

  b64d_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .item             (item),
    .advance          (advance),
    .capacity         (capacity_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_byte_valid   (out_byte_valid),
    .out_done_res     (out_done_res),
    .out_decode_error (out_decode_error),
    .out_byte_count   (out_byte_count)
  );

endmodule

// ===== rtl/core/b64d_in_stage.sv =====
module b64d_in_stage (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [b64d_pkg::CharW-1:0]  in_char,
  input  logic                        in_last_char,
  input  logic                        advance,
  output b64d_pkg::in_item_t          item
);

  logic                       valid_r;
  logic [b64d_pkg::CharW-1:0] ch_r;
  logic                       last_r;
  logic                       take;

  assign in_stall = valid_r && !advance;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ch_r   <= in_char;
      last_r <= in_last_char;
    end
  end

  assign item.valid = valid_r;
  assign item.ch    = ch_r;
  assign item.last  = last_r;

endmodule

// ===== rtl/core/b64d_core.sv =====
module b64d_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  b64d_pkg::in_item_t           item,
  output logic                         advance,
  input  logic [b64d_pkg::CountW-1:0]  capacity,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_byte,
  output logic                         out_byte_valid,
  output logic                         out_done_res,
  output logic                         out_decode_error,
  output logic [b64d_pkg::CountW-1:0]  out_byte_count
);

  typedef enum logic [2:0] {
    PH_FIRST  = 3'd0,
    PH_SECOND = 3'd1,
    PH_THIRD  = 3'd2,
    PH_FOURTH = 3'd3,
    PH_PAD    = 3'd4
  } phase_t;

  phase_t                      phase_r, phase_nxt;
  logic [5:0]                  held_r, held_nxt;
  logic                        closed_r, closed_nxt;
  logic                        err_r, err_nxt;
  logic [b64d_pkg::CountW-1:0] count_r, count_nxt;

  logic                        out_valid_r;
  logic [7:0]                  byte_r;
  logic                        bvalid_r, done_r, derr_r;
  logic [b64d_pkg::CountW-1:0] bcount_r;

  logic [b64d_pkg::ClassW-1:0] cls;
  logic                        is_data, is_pad;
  logic                        have, emit;
  logic [7:0]                  dec_byte;

  assign advance = item.valid && (!out_valid_r || !out_stall);

  assign cls     = b64d_pkg::char_class(item.ch);
  assign is_data = !cls[6];
  assign is_pad  = (cls == b64d_pkg::CLS_PAD);

  always_comb begin
    phase_nxt  = phase_r;
    held_nxt   = held_r;
    closed_nxt = closed_r;
    err_nxt    = err_r;
    have       = 1'b0;
    dec_byte   = 8'h00;
    if (closed_r) begin
      err_nxt = 1'b1;
    end else begin
      case (phase_r)
        PH_FIRST: begin
          if (is_data) begin
            held_nxt  = cls[5:0];
            phase_nxt = PH_SECOND;
          end else begin
            err_nxt = 1'b1;
          end
        end
        PH_SECOND: begin
          if (is_data) begin
            have      = 1'b1;
            dec_byte  = {held_r, cls[5:4]};
            held_nxt  = cls[5:0];
            phase_nxt = PH_THIRD;
          end else begin
            err_nxt = 1'b1;
          end
        end
        PH_THIRD: begin
          if (is_data) begin
            have      = 1'b1;
            dec_byte  = {held_r[3:0], cls[5:2]};
            held_nxt  = cls[5:0];
            phase_nxt = PH_FOURTH;
          end else if (is_pad) begin
            phase_nxt = PH_PAD;
          end else begin
            err_nxt = 1'b1;
          end
        end
        PH_FOURTH: begin
          if (is_data) begin
            have      = 1'b1;
            dec_byte  = {held_r[1:0], cls[5:0]};
            held_nxt  = 6'd0;
            phase_nxt = PH_FIRST;
          end else if (is_pad) begin
            closed_nxt = 1'b1;
          end else begin
            err_nxt = 1'b1;
          end
        end
        default: begin
          if (is_pad) begin
            closed_nxt = 1'b1;
          end else begin
            err_nxt = 1'b1;
          end
        end
      endcase
    end

    emit      = 1'b0;
    count_nxt = count_r;
    if (have) begin
      if (err_nxt || count_r >= capacity) begin
        err_nxt = 1'b1;
      end else begin
        emit      = 1'b1;
        count_nxt = count_r + 1'b1;
      end
    end

    // message ended mid-group after one character, or on a lone third pad
    if (item.last && !closed_nxt && (phase_nxt == PH_SECOND || phase_nxt == PH_PAD)) begin
      err_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FIRST;
      held_r      <= 6'd0;
      closed_r    <= 1'b0;
      err_r       <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
        byte_r      <= emit ? dec_byte : 8'h00;
        bvalid_r    <= emit;
        done_r      <= item.last;
        derr_r      <= err_nxt;
        bcount_r    <= count_nxt;
        if (item.last) begin
          phase_r  <= PH_FIRST;
          held_r   <= 6'd0;
          closed_r <= 1'b0;
          err_r    <= 1'b0;
          count_r  <= '0;
        end else begin
          phase_r  <= phase_nxt;
          held_r   <= held_nxt;
          closed_r <= closed_nxt;
          err_r    <= err_nxt;
          count_r  <= count_nxt;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = byte_r;
  assign out_byte_valid   = bvalid_r;
  assign out_done_res     = done_r;
  assign out_decode_error = derr_r;
  assign out_byte_count   = bcount_r;

endmodule

// ===== tb/tb.sv =====
module tb;

  localparam int LATENCY    = 2;
  localparam int LONG_HOLD  = 300;
  localparam int IDLE_LIMIT = 2000;
  localparam logic [7:0] PAD_CH = "=";

  typedef enum logic [2:0] {PH_FIRST, PH_SECOND, PH_THIRD, PH_FOURTH, PH_PAD4} tb_phase_t;

  typedef struct packed {
    logic [7:0]                  data;
    logic                        data_valid;
    logic                        done;
    logic                        err;
    logic [b64d_pkg::CountW-1:0] count;
  } result_t;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic [b64d_pkg::CharW-1:0]  in_char;
  logic                        in_last_char;
  logic                        out_valid;
  logic                        out_stall;
  logic [7:0]                  out_byte;
  logic                        out_byte_valid;
  logic                        out_done_res;
  logic                        out_decode_error;
  logic [b64d_pkg::CountW-1:0] out_byte_count;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [b64d_pkg::CountW-1:0] cfg_out_capacity;

  base64_stream_decoder_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char          (in_char),
    .in_last_char     (in_last_char),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_byte_valid   (out_byte_valid),
    .out_done_res     (out_done_res),
    .out_decode_error (out_decode_error),
    .out_byte_count   (out_byte_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_out_capacity (cfg_out_capacity)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // decoder state as predicted
  tb_phase_t                   phase;
  logic [5:0]                  held;
  logic                        closed;
  logic                        err_flag;
  logic [b64d_pkg::CountW-1:0] nbytes;
  logic [b64d_pkg::CountW-1:0] capacity;

  result_t decoded_q[$];

  int  fails      = 0;
  int  checked    = 0;
  int  sent       = 0;
  int  cfg_writes = 0;
  int  idle_run   = 0;
  int  stall_pct  = 10;
  int  gap_pct    = 10;
  bit  quiet      = 1'b0;
  bit  long_hold  = 1'b0;
  bit  offering   = 1'b0;

  function automatic logic [6:0] char_sextet(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return 7'(c - "A");
    if (c >= "a" && c <= "z") return 7'(c - "a" + 8'd26);
    if (c >= "0" && c <= "9") return 7'(c - "0" + 8'd52);
    if (c == "+") return 7'd62;
    if (c == "/") return 7'd63;
    if (c == PAD_CH) return b64d_pkg::CLS_PAD;
    return b64d_pkg::CLS_BAD;
  endfunction

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    if (v < 6'd26) return 8'("A") + 8'(v);
    if (v < 6'd52) return 8'("a") + 8'(v - 6'd26);
    if (v < 6'd62) return 8'("0") + 8'(v - 6'd52);
    if (v == 6'd62) return "+";
    return "/";
  endfunction

  function automatic void clear_message();
    phase    = PH_FIRST;
    held     = '0;
    closed   = 1'b0;
    err_flag = 1'b0;
    nbytes   = '0;
  endfunction

  function automatic void decode_char(input logic [7:0] c, input logic last);
    logic [6:0] v;
    logic       have;
    logic [7:0] data;
    result_t    r;
    v    = char_sextet(c);
    have = 1'b0;
    data = '0;
    if (closed) begin
      err_flag = 1'b1;
    end else begin
      case (phase)
        PH_FIRST: begin
          if (v < 7'd64) begin
            held  = v[5:0];
            phase = PH_SECOND;
          end else err_flag = 1'b1;
        end
        PH_SECOND: begin
          if (v < 7'd64) begin
            have  = 1'b1;
            data  = {held, v[5:4]};
            held  = v[5:0];
            phase = PH_THIRD;
          end else err_flag = 1'b1;
        end
        PH_THIRD: begin
          if (v < 7'd64) begin
            have  = 1'b1;
            data  = {held[3:0], v[5:2]};
            held  = v[5:0];
            phase = PH_FOURTH;
          end else if (v == b64d_pkg::CLS_PAD) phase = PH_PAD4;
          else err_flag = 1'b1;
        end
        PH_FOURTH: begin
          if (v < 7'd64) begin
            have  = 1'b1;
            data  = {held[1:0], v[5:0]};
            held  = '0;
            phase = PH_FIRST;
          end else if (v == b64d_pkg::CLS_PAD) closed = 1'b1;
          else err_flag = 1'b1;
        end
        default: begin
          if (v == b64d_pkg::CLS_PAD) closed = 1'b1;
          else err_flag = 1'b1;
        end
      endcase
    end
    if (have) begin
      if (err_flag || nbytes >= capacity) begin
        err_flag = 1'b1;
        have     = 1'b0;
        data     = '0;
      end else nbytes = nbytes + 1'b1;
    end
    if (last && !closed && (phase == PH_SECOND || phase == PH_PAD4)) err_flag = 1'b1;
    r.data       = data;
    r.data_valid = have;
    r.done       = last;
    r.err        = err_flag;
    r.count      = nbytes;
    decoded_q.push_back(r);
    if (last) clear_message();
  endfunction

  // entered and left at a rising edge
  task automatic send_char(input logic [7:0] c, input logic last);
    in_char      <= c;
    in_last_char <= last;
    in_valid     <= 1'b1;
    offering      = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_char(c, last);
    sent++;
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid     <= 1'b0;
      offering      = 1'b0;
      in_char      <= 8'($urandom);
      in_last_char <= 1'($urandom);
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic wait_drained();
    if (offering) begin
      in_valid <= 1'b0;
      offering  = 1'b0;
    end
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [b64d_pkg::CountW-1:0] cap);
    wait_drained();
    cfg_out_capacity <= cap;
    cfg_valid        <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    capacity   = cap;
    cfg_writes++;
  endtask

  // encoded message with random content, sometimes damaged, sometimes pure noise
  task automatic send_random_message();
    logic [7:0]  msg[$];
    logic [23:0] grp;
    int          len, i, pick;
    bit          padded;
    len    = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
    padded = $urandom_range(0, 1);
    for (i = 0; i < len; i += 3) begin
      grp = 24'($urandom);
      msg.push_back(sextet_char(grp[23:18]));
      msg.push_back(sextet_char(grp[17:12]));
      if (i + 1 < len) msg.push_back(sextet_char(grp[11:6]));
      else if (padded) msg.push_back(PAD_CH);
      if (i + 2 < len) msg.push_back(sextet_char(grp[5:0]));
      else if (padded) msg.push_back(PAD_CH);
    end
    pick = $urandom_range(0, 99);
    if (msg.size() == 0 || pick >= 90) begin
      msg.delete();
      repeat ($urandom_range(1, 8)) begin
        if (pick[0]) msg.push_back(8'($urandom));
        else if ($urandom_range(0, 4) == 0) msg.push_back(PAD_CH);
        else msg.push_back(sextet_char(6'($urandom)));
      end
    end else if (pick >= 84) begin
      msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom);
    end else if (pick >= 78) begin
      msg.insert($urandom_range(0, msg.size()), PAD_CH);
    end else if (pick >= 72) begin
      msg.push_back(sextet_char(6'($urandom)));
    end else if (pick >= 68 && msg.size() > 1) begin
      void'(msg.pop_back());
    end
    for (i = 0; i < msg.size(); i++) send_char(msg[i], i == msg.size() - 1);
  endtask

  task automatic test_directed();
    send_text("TWFuQQ");
    send_text("/+9aTQ==");
    send_char(PAD_CH, 1'b0);
    send_char(8'hff, 1'b0);
    send_char(8'h00, 1'b1);
    send_text("QQ=");
    send_text("A=");
    send_text("TQ==A");
    send_text("Q");
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int target;
    stall_pct = 10;
    gap_pct   = 10;
    target    = sent + 1250;
    while (sent < target) send_random_message();
  endtask

  task automatic test_capacity_settings();
    int k, target;
    logic [b64d_pkg::CountW-1:0] cap;
    for (k = 0; k < 7; k++) begin
      case (k)
        0:       cap = '0;
        1:       cap = 10'd1;
        2:       cap = 10'd2;
        3:       cap = 10'($urandom_range(100, 1022));
        6:       cap = 10'd1023;
        default: cap = 10'($urandom_range(3, 60));
      endcase
      write_capacity(cap);
      target = sent + 60;
      while (sent < target) send_random_message();
    end
  endtask

  task automatic test_backpressure();
    int target;
    wait_drained();
    long_hold = 1'b1;
    target    = sent + 40;
    while (sent < target) send_random_message();
    wait_drained();
    stall_pct = 40;
    gap_pct   = 40;
    target    = sent + 40;
    while (sent < target) send_random_message();
  endtask

  task automatic test_full_rate();
    int target;
    wait_drained();
    quiet  = 1'b1;
    target = sent + 200;
    while (sent < target) send_random_message();
  endtask

  task automatic check_field(input string name, input logic [b64d_pkg::CountW-1:0] want,
                             input logic [b64d_pkg::CountW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : result_checker
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        $error("result item with nothing expected");
        fails++;
      end else begin
        want = decoded_q.pop_front();
        check_field("out_byte", 10'(want.data), 10'(out_byte));
        check_field("out_byte_valid", 10'(want.data_valid), 10'(out_byte_valid));
        check_field("out_done_res", 10'(want.done), 10'(out_done_res));
        check_field("out_decode_error", 10'(want.err), 10'(out_decode_error));
        check_field("out_byte_count", want.count, out_byte_count);
        checked++;
      end
    end
  end

  initial begin : receiver
    int n;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        for (n = 0; n < LONG_HOLD; n++) @(posedge clk);
        out_stall <= 1'b0;
        long_hold  = 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_run = 0;
      else
        idle_run++;
      if (idle_run >= IDLE_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_char          <= '0;
    in_last_char     <= 1'b0;
    cfg_valid        <= 1'b0;
    cfg_out_capacity <= '0;
    clear_message();
    capacity = 10'd1023;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_traffic();
    test_capacity_settings();
    test_backpressure();
    test_full_rate();
    wait_drained();
    $display("Sent %0d characters: directed cases, random and damaged messages, long hold-off,",
             sent);
    $display("full-rate streaming; %0d results checked over %0d capacity writes.",
             checked, cfg_writes);
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/b64d_pkg.sv
rtl/core/b64d_in_stage.sv
rtl/core/b64d_core.sv
rtl/core/base64_stream_decoder_top.sv
tb/tb.sv
